// ===== rtl/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg
// Types, codes and fixed tables of the fuzzy pendulum controller.
// ----------------------------------------------------------------------------
package fpc_pkg;

    typedef struct packed {
        logic signed [15:0] cart_position;
        logic signed [15:0] cart_velocity;
        logic signed [15:0] pole_angle;
        logic signed [15:0] pole_rate;
    } fpc_in_t;

    typedef struct packed {
        logic signed [16:0] drive_force;
        logic               no_rule_fired;
    } fpc_out_t;

    localparam int QUOT_W      = 17;
    localparam int STEP_W      = 5;
    localparam int TABLE_RULES = 50;
    localparam int MEM_DEPTH   = 20;
    localparam int MEM_AW      = 5;
    localparam logic [16:0] FORCE_MAX = 17'd65280;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    localparam logic [1:0] CFG_VERY_LARGE = 2'd0;
    localparam logic [1:0] CFG_LARGE      = 2'd1;
    localparam logic [1:0] CFG_MEDIUM     = 2'd2;
    localparam logic [1:0] CFG_SMALL      = 2'd3;

    typedef enum logic [3:0] {
        OUT_NVL = 4'd0,
        OUT_NL  = 4'd1,
        OUT_NM  = 4'd2,
        OUT_NS  = 4'd3,
        OUT_ZE  = 4'd4,
        OUT_PS  = 4'd5,
        OUT_PM  = 4'd6,
        OUT_PL  = 4'd7,
        OUT_PVL = 4'd8
    } out_code_t;

    localparam logic [1:0] VAR_POS  = 2'd0;
    localparam logic [1:0] VAR_VEL  = 2'd1;
    localparam logic [1:0] VAR_ANG  = 2'd2;
    localparam logic [1:0] VAR_RATE = 2'd3;

    localparam logic [2:0] SET_NL = 3'd0;
    localparam logic [2:0] SET_NS = 3'd1;
    localparam logic [2:0] SET_ZE = 3'd2;
    localparam logic [2:0] SET_PS = 3'd3;
    localparam logic [2:0] SET_PL = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_RAMP_DIV,
        ST_MEM_WR,
        ST_RULE,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINAL_DIV,
        ST_OUT_WAIT
    } state_t;

    // edges per variable, thousandths; index {variable, edge}
    typedef int edge_tab_t [16];

    localparam edge_tab_t EDGE_MILLI_LO = '{
        -200, -150,    0,  150,
        -1600, -200,  100, 1500,
        -500,  -50,    0,  400,
        -200, -100,   80,  150
    };
    localparam edge_tab_t EDGE_MILLI_HI = '{
        -150,    0,  150,  200,
        -1500, -100,  200, 1600,
        -400,    0,   50,  500,
        -150,  -80,  100,  200
    };

    typedef struct packed {
        logic [MEM_AW-1:0] addr_a;
        logic [MEM_AW-1:0] addr_b;
        out_code_t         code;
    } rule_t;

    function automatic rule_t mk_rule(input logic [1:0] v0, input logic [2:0] s0,
                                      input logic [1:0] v1, input logic [2:0] s1,
                                      input out_code_t o);
        rule_t r;
        r.addr_a = MEM_AW'(v0) * MEM_AW'(5) + MEM_AW'(s0);
        r.addr_b = MEM_AW'(v1) * MEM_AW'(5) + MEM_AW'(s1);
        r.code   = o;
        return r;
    endfunction

    function automatic rule_t rule_entry(input logic [5:0] idx);
        rule_t r;
        r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_ZE, OUT_ZE);
        case (idx)
            6'd0:  r = mk_rule(VAR_ANG, SET_NL, VAR_RATE, SET_NL, OUT_NVL);
            6'd1:  r = mk_rule(VAR_ANG, SET_NS, VAR_RATE, SET_NL, OUT_NVL);
            6'd2:  r = mk_rule(VAR_ANG, SET_NL, VAR_RATE, SET_NS, OUT_NVL);
            6'd3:  r = mk_rule(VAR_ANG, SET_NL, VAR_RATE, SET_ZE, OUT_NL);
            6'd4:  r = mk_rule(VAR_ANG, SET_NS, VAR_RATE, SET_NS, OUT_NL);
            6'd5:  r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_NL, OUT_ZE);
            6'd6:  r = mk_rule(VAR_ANG, SET_PS, VAR_RATE, SET_NL, OUT_PL);
            6'd7:  r = mk_rule(VAR_ANG, SET_NS, VAR_RATE, SET_ZE, OUT_NL);
            6'd8:  r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_NS, OUT_ZE);
            6'd9:  r = mk_rule(VAR_ANG, SET_PL, VAR_RATE, SET_NL, OUT_PL);
            6'd10: r = mk_rule(VAR_ANG, SET_NL, VAR_RATE, SET_PS, OUT_NL);
            6'd11: r = mk_rule(VAR_ANG, SET_NS, VAR_RATE, SET_PS, OUT_NL);
            6'd12: r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_ZE, OUT_ZE);
            6'd13: r = mk_rule(VAR_ANG, SET_PS, VAR_RATE, SET_NS, OUT_PL);
            6'd14: r = mk_rule(VAR_ANG, SET_PL, VAR_RATE, SET_NS, OUT_PL);
            6'd15: r = mk_rule(VAR_ANG, SET_NL, VAR_RATE, SET_PL, OUT_NL);
            6'd16: r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_PS, OUT_ZE);
            6'd17: r = mk_rule(VAR_ANG, SET_PS, VAR_RATE, SET_ZE, OUT_PL);
            6'd18: r = mk_rule(VAR_ANG, SET_NS, VAR_RATE, SET_PL, OUT_NL);
            6'd19: r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_PL, OUT_ZE);
            6'd20: r = mk_rule(VAR_ANG, SET_PS, VAR_RATE, SET_PS, OUT_PL);
            6'd21: r = mk_rule(VAR_ANG, SET_PL, VAR_RATE, SET_ZE, OUT_PL);
            6'd22: r = mk_rule(VAR_ANG, SET_PS, VAR_RATE, SET_PL, OUT_PVL);
            6'd23: r = mk_rule(VAR_ANG, SET_PL, VAR_RATE, SET_PS, OUT_PVL);
            6'd24: r = mk_rule(VAR_ANG, SET_PL, VAR_RATE, SET_PL, OUT_PVL);
            6'd25: r = mk_rule(VAR_POS, SET_PL, VAR_VEL, SET_PL, OUT_PM);
            6'd26: r = mk_rule(VAR_POS, SET_PL, VAR_VEL, SET_PS, OUT_PM);
            6'd27: r = mk_rule(VAR_POS, SET_PS, VAR_VEL, SET_PL, OUT_PM);
            6'd28: r = mk_rule(VAR_POS, SET_NS, VAR_VEL, SET_PL, OUT_NM);
            6'd29: r = mk_rule(VAR_POS, SET_ZE, VAR_VEL, SET_PL, OUT_ZE);
            6'd30: r = mk_rule(VAR_POS, SET_PS, VAR_VEL, SET_PS, OUT_PM);
            6'd31: r = mk_rule(VAR_POS, SET_PL, VAR_VEL, SET_ZE, OUT_PM);
            6'd32: r = mk_rule(VAR_POS, SET_ZE, VAR_VEL, SET_PS, OUT_ZE);
            6'd33: r = mk_rule(VAR_POS, SET_PS, VAR_VEL, SET_ZE, OUT_PM);
            6'd34: r = mk_rule(VAR_POS, SET_PL, VAR_VEL, SET_NS, OUT_PM);
            6'd35: r = mk_rule(VAR_POS, SET_NL, VAR_VEL, SET_PL, OUT_NM);
            6'd36: r = mk_rule(VAR_POS, SET_NS, VAR_VEL, SET_PS, OUT_NM);
            6'd37: r = mk_rule(VAR_POS, SET_ZE, VAR_VEL, SET_ZE, OUT_ZE);
            6'd38: r = mk_rule(VAR_POS, SET_PS, VAR_VEL, SET_NS, OUT_PM);
            6'd39: r = mk_rule(VAR_POS, SET_PL, VAR_VEL, SET_NL, OUT_PM);
            6'd40: r = mk_rule(VAR_POS, SET_NL, VAR_VEL, SET_PS, OUT_NM);
            6'd41: r = mk_rule(VAR_POS, SET_NS, VAR_VEL, SET_ZE, OUT_NM);
            6'd42: r = mk_rule(VAR_POS, SET_ZE, VAR_VEL, SET_NS, OUT_ZE);
            6'd43: r = mk_rule(VAR_POS, SET_NL, VAR_VEL, SET_ZE, OUT_NM);
            6'd44: r = mk_rule(VAR_POS, SET_NS, VAR_VEL, SET_NS, OUT_NM);
            6'd45: r = mk_rule(VAR_POS, SET_ZE, VAR_VEL, SET_NL, OUT_ZE);
            6'd46: r = mk_rule(VAR_POS, SET_PS, VAR_VEL, SET_NL, OUT_PM);
            6'd47: r = mk_rule(VAR_POS, SET_NL, VAR_VEL, SET_NS, OUT_NM);
            6'd48: r = mk_rule(VAR_POS, SET_NS, VAR_VEL, SET_NL, OUT_NM);
            6'd49: r = mk_rule(VAR_POS, SET_NL, VAR_VEL, SET_NL, OUT_NM);
            default: r = mk_rule(VAR_ANG, SET_ZE, VAR_RATE, SET_ZE, OUT_ZE);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/fpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fpc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

// ===== rtl/fpc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpc_divider #(
    parameter int DW = 22
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpc_pkg::div_ctl_t      ctl,
    input  logic [DW-2:0]          rem_init,
    input  logic [fpc_pkg::QUOT_W-1:0] low_init,
    input  logic [DW-2:0]          divisor,
    output logic [fpc_pkg::QUOT_W-1:0] quotient,
    output logic                   done
);
    import fpc_pkg::*;

    logic [DW-2:0]       rem_reg, rem_next;
    logic [QUOT_W-1:0]   low_reg, low_next;
    logic [QUOT_W-1:0]   quo_reg, quo_next;
    logic [DW-2:0]       div_reg;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DW-1:0]       trial;
    logic [DW-1:0]       diff;
    logic                ge;

    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = rem_init;
            low_next  = low_init;
            quo_next  = '0;
            cnt_next  = ctl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-2:0] : trial[DW-2:0];
            low_next = {low_reg[QUOT_W-2:0], 1'b0};
            quo_next = {quo_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        if (ctl.start)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/fuzzy_pendulum_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_pendulum_controller
// Zero-order Sugeno fuzzy controller for a cart-pole, one shared divider.
// ----------------------------------------------------------------------------
// Sequence from accept: edge ramps, divided only where the input lies on a
// slope; membership writes; the rule scan; and the final divide, skipped
// when no rule fires.
// Throughput: one item at a time; in_stall is high from accept until the
// result is loaded into the output register.
// Reset: control state cleared, registers return to 120/40/13/5.
module fuzzy_pendulum_controller #(
    parameter int NUM_RULES        = 50,
    parameter int INPUT_FRAC_BITS  = 12,
    parameter int MEMBER_FRAC_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fpc_pkg::fpc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output fpc_pkg::fpc_out_t out_data,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import fpc_pkg::*;

    localparam int MFB = MEMBER_FRAC_BITS;
    localparam int MW  = MFB + 1;
    localparam int SWW = MFB + 7;
    localparam int SW  = MFB + 17;
    localparam int PW  = MW + 10;
    localparam int DW  = ((MFB + 10) > (INPUT_FRAC_BITS + 3)) ? (MFB + 10)
                                                               : (INPUT_FRAC_BITS + 3);
    localparam int RULES_USED = (NUM_RULES < TABLE_RULES) ? NUM_RULES : TABLE_RULES;
    localparam int RIW = (RULES_USED > 1) ? $clog2(RULES_USED) : 1;
    localparam logic [MW-1:0] ONE = MW'(1) << MFB;

    function automatic int to_fixed(input int milli);
        longint mag;
        longint r;
        mag = (milli < 0) ? -longint'(milli) : longint'(milli);
        r   = (mag * (longint'(1) << INPUT_FRAC_BITS) + 500) / 1000;
        return (milli < 0) ? -int'(r) : int'(r);
    endfunction

    function automatic edge_tab_t build_edges(input edge_tab_t milli);
        edge_tab_t t;
        for (int i = 0; i < 16; i++)
        begin
            t[i] = to_fixed(milli[i]);
        end
        return t;
    endfunction

    localparam edge_tab_t EDGE_LO = build_edges(EDGE_MILLI_LO);
    localparam edge_tab_t EDGE_HI = build_edges(EDGE_MILLI_HI);

    state_t state_reg, state_next;

    fpc_in_t         in_reg;
    logic [1:0]      var_reg;
    logic [1:0]      edge_reg;
    logic [2:0]      set_reg;
    logic [RIW-1:0]  rule_idx_reg;
    logic [MW-1:0]   r_reg [4];
    logic            p_valid_reg;
    out_code_t       p_code_reg;
    logic [SWW-1:0]  sum_w_reg;
    logic signed [SW-1:0] sum_ws_reg;
    logic [7:0]      vl_reg, lg_reg, md_reg, sm_reg;
    logic            out_valid_reg;
    fpc_out_t        out_reg;

    // control strobes
    logic accept_in, edge_fixed, ramp_start, ramp_store, mem_we;
    logic rule_issue, final_start, out_load;

    logic signed [15:0] x_sel;
    logic signed [31:0] x_ext, lo_v, hi_v, x_off, width;
    logic               in_slope;
    logic [3:0]         edge_idx;
    rule_t              rule_cur;
    logic [MW-1:0]      rd_a, rd_b, w_min, mem_wdata;
    logic [MEM_AW-1:0]  mem_waddr;
    logic signed [9:0]  sing;
    logic signed [PW-1:0] prod;
    logic [SW-1:0]      abs_ws;
    div_ctl_t           div_ctl;
    logic [DW-2:0]      div_rem, div_den;
    logic [QUOT_W-1:0]  div_low, div_q;
    logic               div_done;
    logic [QUOT_W-1:0]  mag;
    fpc_out_t           result;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        case (var_reg)
            VAR_POS: x_sel = in_reg.cart_position;
            VAR_VEL: x_sel = in_reg.cart_velocity;
            VAR_ANG: x_sel = in_reg.pole_angle;
            default: x_sel = in_reg.pole_rate;
        endcase
    end

    assign edge_idx = {var_reg, edge_reg};
    assign x_ext    = 32'(x_sel);
    assign lo_v     = EDGE_LO[edge_idx];
    assign hi_v     = EDGE_HI[edge_idx];
    assign x_off    = x_ext - lo_v;
    assign width    = hi_v - lo_v;
    assign in_slope = (x_ext > lo_v) && (x_ext < hi_v);

    assign rule_cur = rule_entry(6'(rule_idx_reg));

    always_comb
    begin
        case (set_reg)
            SET_NL:  mem_wdata = ONE - r_reg[0];
            SET_NS:  mem_wdata = r_reg[0] - r_reg[1];
            SET_ZE:  mem_wdata = r_reg[1] - r_reg[2];
            SET_PS:  mem_wdata = r_reg[2] - r_reg[3];
            default: mem_wdata = r_reg[3];
        endcase
    end

    assign mem_waddr = MEM_AW'(var_reg) * MEM_AW'(5) + MEM_AW'(set_reg);

    fpc_ram #(
        .WIDTH (MW),
        .DEPTH (MEM_DEPTH)
    ) u_mu_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (rule_cur.addr_a),
        .raddr_b (rule_cur.addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign w_min = (rd_a < rd_b) ? rd_a : rd_b;

    always_comb
    begin
        case (p_code_reg)
            OUT_NVL: sing = -$signed({2'b00, vl_reg});
            OUT_NL:  sing = -$signed({2'b00, lg_reg});
            OUT_NM:  sing = -$signed({2'b00, md_reg});
            OUT_NS:  sing = -$signed({2'b00, sm_reg});
            OUT_PS:  sing = $signed({2'b00, sm_reg});
            OUT_PM:  sing = $signed({2'b00, md_reg});
            OUT_PL:  sing = $signed({2'b00, lg_reg});
            OUT_PVL: sing = $signed({2'b00, vl_reg});
            default: sing = '0;
        endcase
    end

    assign prod   = $signed({1'b0, w_min}) * sing;
    assign abs_ws = sum_ws_reg[SW-1] ? SW'(-sum_ws_reg) : SW'(sum_ws_reg);

    always_comb
    begin
        div_ctl.start = ramp_start || final_start;
        div_ctl.steps = final_start ? STEP_W'(QUOT_W) : STEP_W'(MFB);
        if (final_start)
        begin
            div_rem = (DW-1)'(abs_ws >> 9);
            div_low = {abs_ws[8:0], 8'b0};
            div_den = (DW-1)'(sum_w_reg);
        end
        else
        begin
            div_rem = x_off[DW-2:0];
            div_low = '0;
            div_den = width[DW-2:0];
        end
    end

    fpc_divider #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem),
        .low_init (div_low),
        .divisor  (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        mag = (div_q > FORCE_MAX) ? FORCE_MAX : div_q;
        if (sum_w_reg == '0)
        begin
            result.drive_force   = '0;
            result.no_rule_fired = 1'b1;
        end
        else
        begin
            result.drive_force   = sum_ws_reg[SW-1] ? -$signed(mag) : $signed(mag);
            result.no_rule_fired = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EDGE;
            ST_EDGE:
                if (in_slope)
                    state_next = ST_RAMP_DIV;
                else if (edge_reg == 2'd3)
                    state_next = ST_MEM_WR;
            ST_RAMP_DIV:
                if (div_done)
                    state_next = (edge_reg == 2'd3) ? ST_MEM_WR : ST_EDGE;
            ST_MEM_WR:
                if (set_reg == SET_PL)
                    state_next = (var_reg == VAR_RATE) ? ST_RULE : ST_EDGE;
            ST_RULE:
                if (rule_idx_reg == RIW'(RULES_USED - 1))
                    state_next = ST_DRAIN;
            ST_DRAIN:
                state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = (sum_w_reg == '0) ? ST_OUT_WAIT : ST_FINAL_DIV;
            ST_FINAL_DIV:
                if (div_done)
                    state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        accept_in   = 1'b0;
        edge_fixed  = 1'b0;
        ramp_start  = 1'b0;
        ramp_store  = 1'b0;
        mem_we      = 1'b0;
        rule_issue  = 1'b0;
        final_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:      accept_in   = in_valid;
            ST_EDGE:
            begin
                edge_fixed = !in_slope;
                ramp_start = in_slope;
            end
            ST_RAMP_DIV:  ramp_store  = div_done;
            ST_MEM_WR:    mem_we      = 1'b1;
            ST_RULE:      rule_issue  = 1'b1;
            ST_DRAIN:     ;
            ST_DECIDE:    final_start = (sum_w_reg != '0);
            ST_FINAL_DIV: ;
            ST_OUT_WAIT:  out_load    = !out_valid_reg || !out_stall;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            var_reg       <= '0;
            edge_reg      <= '0;
            set_reg       <= '0;
            rule_idx_reg  <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            vl_reg        <= 8'd120;
            lg_reg        <= 8'd40;
            md_reg        <= 8'd13;
            sm_reg        <= 8'd5;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= rule_issue;
            if (accept_in)
            begin
                var_reg      <= '0;
                edge_reg     <= '0;
                set_reg      <= '0;
                rule_idx_reg <= '0;
            end
            if (edge_fixed || ramp_store)
            begin
                edge_reg <= edge_reg + 2'd1;
            end
            if (mem_we)
            begin
                if (set_reg == SET_PL)
                begin
                    set_reg <= '0;
                    var_reg <= var_reg + 2'd1;
                end
                else
                begin
                    set_reg <= set_reg + 3'd1;
                end
            end
            if (rule_issue)
            begin
                rule_idx_reg <= rule_idx_reg + RIW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_VERY_LARGE: vl_reg <= cfg_data;
                    CFG_LARGE:      lg_reg <= cfg_data;
                    CFG_MEDIUM:     md_reg <= cfg_data;
                    CFG_SMALL:      sm_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_reg     <= in_data;
            sum_w_reg  <= '0;
            sum_ws_reg <= '0;
        end
        else if (p_valid_reg)
        begin
            sum_w_reg  <= sum_w_reg + SWW'(w_min);
            sum_ws_reg <= sum_ws_reg + SW'(prod);
        end
        p_code_reg <= rule_cur.code;
        if (edge_fixed)
        begin
            r_reg[edge_reg] <= (x_ext <= lo_v) ? '0 : ONE;
        end
        else if (ramp_store)
        begin
            r_reg[edge_reg] <= MW'(div_q[MFB-1:0]);
        end
        if (out_load)
        begin
            out_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_load_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == ST_OUT_WAIT))
        else $error("result loaded outside output wait");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.no_rule_fired) |-> (out_data.drive_force == '0))
        else $error("no_rule_fired with nonzero force");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RAMP_DIV || state_reg == ST_FINAL_DIV))
        else $error("divider finished outside a divide state");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EDGE && var_reg == VAR_POS))
        else $error("item accepted but fuzzification did not start");
`endif

endmodule

// ===== tb/fuzzy_pendulum_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_pendulum_controller_tb
// Drives cart-pole samples through the fuzzy controller under random valid
// and stall gaps and several output-level settings. Each force and
// no-weight flag is checked against a fixed-point rule evaluation that is
// worked out inside this bench.
// ----------------------------------------------------------------------------
module fuzzy_pendulum_controller_tb;
    import fpc_pkg::*;

    localparam int SHP_LEFT  = 0;
    localparam int SHP_RIGHT = 1;
    localparam int SHP_TRAP  = 2;
    localparam int ONE_Q     = 4096;
    localparam int SETTLE    = 250;
    localparam int WDOG_MAX  = 5000;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        logic [1:0] va;
        logic [2:0] sa;
        logic [1:0] vb;
        logic [2:0] sb;
        out_code_t  oc;
    } rule_rec_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    fpc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    fpc_out_t out_data;
    logic     cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int        mf_shape [4][5];
    int        mf_milli [4][5][4];
    rule_rec_t rules [TABLE_RULES];
    logic [7:0] level [4];

    fpc_out_t  force_q[$];
    int        mismatches;
    int        wdog;
    int        hold_req;
    bit        no_gap;

    fuzzy_pendulum_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------- prediction ----------------
    function automatic longint to_q(input int milli);
        longint mag;
        longint r;
        mag = (milli < 0) ? -longint'(milli) : longint'(milli);
        r = (mag * ONE_Q + 500) / 1000;
        return (milli < 0) ? -r : r;
    endfunction

    function automatic longint ramp(input longint x, input longint lo, input longint hi);
        if (x <= lo)
            return 0;
        if (x >= hi)
            return ONE_Q;
        return (x - lo) * ONE_Q / (hi - lo);
    endfunction

    function automatic longint grade(input longint x, input int v, input int s);
        longint a;
        longint b;
        longint c;
        longint d;
        a = to_q(mf_milli[v][s][0]);
        b = to_q(mf_milli[v][s][1]);
        c = to_q(mf_milli[v][s][2]);
        d = to_q(mf_milli[v][s][3]);
        if (mf_shape[v][s] == SHP_LEFT)
            return ONE_Q - ramp(x, a, b);
        if (mf_shape[v][s] == SHP_RIGHT)
            return ramp(x, a, b);
        if (x <= a || x >= d)
            return 0;
        if (x >= b && x <= c)
            return ONE_Q;
        if (x < b)
            return ramp(x, a, b);
        return ONE_Q - ramp(x, c, d);
    endfunction

    function automatic longint level_of(input out_code_t oc);
        case (oc)
            OUT_NVL: return -longint'(level[CFG_VERY_LARGE]);
            OUT_NL:  return -longint'(level[CFG_LARGE]);
            OUT_NM:  return -longint'(level[CFG_MEDIUM]);
            OUT_NS:  return -longint'(level[CFG_SMALL]);
            OUT_PS:  return longint'(level[CFG_SMALL]);
            OUT_PM:  return longint'(level[CFG_MEDIUM]);
            OUT_PL:  return longint'(level[CFG_LARGE]);
            OUT_PVL: return longint'(level[CFG_VERY_LARGE]);
            default: return 0;
        endcase
    endfunction

    function automatic fpc_out_t predict_force(input fpc_in_t d);
        longint   x [4];
        longint   mu [4][5];
        longint   sw;
        longint   sws;
        longint   wa;
        longint   wb;
        longint   w;
        longint   f;
        fpc_out_t r;
        x[VAR_POS]  = d.cart_position;
        x[VAR_VEL]  = d.cart_velocity;
        x[VAR_ANG]  = d.pole_angle;
        x[VAR_RATE] = d.pole_rate;
        for (int v = 0; v < 4; v++)
            for (int s = 0; s < 5; s++)
                mu[v][s] = grade(x[v], v, s);
        sw = 0;
        sws = 0;
        for (int i = 0; i < TABLE_RULES; i++)
        begin
            wa = mu[rules[i].va][rules[i].sa];
            wb = mu[rules[i].vb][rules[i].sb];
            w = (wa < wb) ? wa : wb;
            sw += w;
            sws += w * level_of(rules[i].oc);
        end
        if (sw == 0)
        begin
            r.drive_force = '0;
            r.no_rule_fired = 1'b1;
            return r;
        end
        f = (sws * 256) / sw;
        if (f > 65280)
            f = 65280;
        if (f < -65280)
            f = -65280;
        r.drive_force = f[16:0];
        r.no_rule_fired = 1'b0;
        return r;
    endfunction

    function automatic rule_rec_t rule_of(input logic [1:0] va, input logic [2:0] sa,
                                          input logic [1:0] vb, input logic [2:0] sb,
                                          input out_code_t oc);
        rule_rec_t r;
        r.va = va;
        r.sa = sa;
        r.vb = vb;
        r.sb = sb;
        r.oc = oc;
        return r;
    endfunction

    task automatic set_mf(input int v, input int s, input int shp,
                          input int a, input int b, input int c, input int d);
        mf_shape[v][s] = shp;
        mf_milli[v][s][0] = a;
        mf_milli[v][s][1] = b;
        mf_milli[v][s][2] = c;
        mf_milli[v][s][3] = d;
    endtask

    task automatic build_tables();
        set_mf(VAR_POS, SET_NL, SHP_LEFT, -200, -150, 0, 0);
        set_mf(VAR_POS, SET_NS, SHP_TRAP, -200, -150, -150, 0);
        set_mf(VAR_POS, SET_ZE, SHP_TRAP, -150, 0, 0, 150);
        set_mf(VAR_POS, SET_PS, SHP_TRAP, 0, 150, 150, 200);
        set_mf(VAR_POS, SET_PL, SHP_RIGHT, 150, 200, 0, 0);
        set_mf(VAR_VEL, SET_NL, SHP_LEFT, -1600, -1500, 0, 0);
        set_mf(VAR_VEL, SET_NS, SHP_TRAP, -1600, -1500, -200, -100);
        set_mf(VAR_VEL, SET_ZE, SHP_TRAP, -200, -100, 100, 200);
        set_mf(VAR_VEL, SET_PS, SHP_TRAP, 100, 200, 1500, 1600);
        set_mf(VAR_VEL, SET_PL, SHP_RIGHT, 1500, 1600, 0, 0);
        set_mf(VAR_ANG, SET_NL, SHP_LEFT, -500, -400, 0, 0);
        set_mf(VAR_ANG, SET_NS, SHP_TRAP, -500, -400, -50, 0);
        set_mf(VAR_ANG, SET_ZE, SHP_TRAP, -50, 0, 0, 50);
        set_mf(VAR_ANG, SET_PS, SHP_TRAP, 0, 50, 400, 500);
        set_mf(VAR_ANG, SET_PL, SHP_RIGHT, 400, 500, 0, 0);
        set_mf(VAR_RATE, SET_NL, SHP_LEFT, -200, -150, 0, 0);
        set_mf(VAR_RATE, SET_NS, SHP_TRAP, -200, -150, -100, -80);
        set_mf(VAR_RATE, SET_ZE, SHP_TRAP, -100, -80, 80, 100);
        set_mf(VAR_RATE, SET_PS, SHP_TRAP, 80, 100, 150, 200);
        set_mf(VAR_RATE, SET_PL, SHP_RIGHT, 150, 200, 0, 0);

        rules[0]  = rule_of(VAR_ANG, SET_NL, VAR_RATE, SET_NL, OUT_NVL);
        rules[1]  = rule_of(VAR_ANG, SET_NS, VAR_RATE, SET_NL, OUT_NVL);
        rules[2]  = rule_of(VAR_ANG, SET_NL, VAR_RATE, SET_NS, OUT_NVL);
        rules[3]  = rule_of(VAR_ANG, SET_NL, VAR_RATE, SET_ZE, OUT_NL);
        rules[4]  = rule_of(VAR_ANG, SET_NS, VAR_RATE, SET_NS, OUT_NL);
        rules[5]  = rule_of(VAR_ANG, SET_ZE, VAR_RATE, SET_NL, OUT_ZE);
        rules[6]  = rule_of(VAR_ANG, SET_PS, VAR_RATE, SET_NL, OUT_PL);
        rules[7]  = rule_of(VAR_ANG, SET_NS, VAR_RATE, SET_ZE, OUT_NL);
        rules[8]  = rule_of(VAR_ANG, SET_ZE, VAR_RATE, SET_NS, OUT_ZE);
        rules[9]  = rule_of(VAR_ANG, SET_PL, VAR_RATE, SET_NL, OUT_PL);
        rules[10] = rule_of(VAR_ANG, SET_NL, VAR_RATE, SET_PS, OUT_NL);
        rules[11] = rule_of(VAR_ANG, SET_NS, VAR_RATE, SET_PS, OUT_NL);
        rules[12] = rule_of(VAR_ANG, SET_ZE, VAR_RATE, SET_ZE, OUT_ZE);
        rules[13] = rule_of(VAR_ANG, SET_PS, VAR_RATE, SET_NS, OUT_PL);
        rules[14] = rule_of(VAR_ANG, SET_PL, VAR_RATE, SET_NS, OUT_PL);
        rules[15] = rule_of(VAR_ANG, SET_NL, VAR_RATE, SET_PL, OUT_NL);
        rules[16] = rule_of(VAR_ANG, SET_ZE, VAR_RATE, SET_PS, OUT_ZE);
        rules[17] = rule_of(VAR_ANG, SET_PS, VAR_RATE, SET_ZE, OUT_PL);
        rules[18] = rule_of(VAR_ANG, SET_NS, VAR_RATE, SET_PL, OUT_NL);
        rules[19] = rule_of(VAR_ANG, SET_ZE, VAR_RATE, SET_PL, OUT_ZE);
        rules[20] = rule_of(VAR_ANG, SET_PS, VAR_RATE, SET_PS, OUT_PL);
        rules[21] = rule_of(VAR_ANG, SET_PL, VAR_RATE, SET_ZE, OUT_PL);
        rules[22] = rule_of(VAR_ANG, SET_PS, VAR_RATE, SET_PL, OUT_PVL);
        rules[23] = rule_of(VAR_ANG, SET_PL, VAR_RATE, SET_PS, OUT_PVL);
        rules[24] = rule_of(VAR_ANG, SET_PL, VAR_RATE, SET_PL, OUT_PVL);
        rules[25] = rule_of(VAR_POS, SET_PL, VAR_VEL, SET_PL, OUT_PM);
        rules[26] = rule_of(VAR_POS, SET_PL, VAR_VEL, SET_PS, OUT_PM);
        rules[27] = rule_of(VAR_POS, SET_PS, VAR_VEL, SET_PL, OUT_PM);
        rules[28] = rule_of(VAR_POS, SET_NS, VAR_VEL, SET_PL, OUT_NM);
        rules[29] = rule_of(VAR_POS, SET_ZE, VAR_VEL, SET_PL, OUT_ZE);
        rules[30] = rule_of(VAR_POS, SET_PS, VAR_VEL, SET_PS, OUT_PM);
        rules[31] = rule_of(VAR_POS, SET_PL, VAR_VEL, SET_ZE, OUT_PM);
        rules[32] = rule_of(VAR_POS, SET_ZE, VAR_VEL, SET_PS, OUT_ZE);
        rules[33] = rule_of(VAR_POS, SET_PS, VAR_VEL, SET_ZE, OUT_PM);
        rules[34] = rule_of(VAR_POS, SET_PL, VAR_VEL, SET_NS, OUT_PM);
        rules[35] = rule_of(VAR_POS, SET_NL, VAR_VEL, SET_PL, OUT_NM);
        rules[36] = rule_of(VAR_POS, SET_NS, VAR_VEL, SET_PS, OUT_NM);
        rules[37] = rule_of(VAR_POS, SET_ZE, VAR_VEL, SET_ZE, OUT_ZE);
        rules[38] = rule_of(VAR_POS, SET_PS, VAR_VEL, SET_NS, OUT_PM);
        rules[39] = rule_of(VAR_POS, SET_PL, VAR_VEL, SET_NL, OUT_PM);
        rules[40] = rule_of(VAR_POS, SET_NL, VAR_VEL, SET_PS, OUT_NM);
        rules[41] = rule_of(VAR_POS, SET_NS, VAR_VEL, SET_ZE, OUT_NM);
        rules[42] = rule_of(VAR_POS, SET_ZE, VAR_VEL, SET_NS, OUT_ZE);
        rules[43] = rule_of(VAR_POS, SET_NL, VAR_VEL, SET_ZE, OUT_NM);
        rules[44] = rule_of(VAR_POS, SET_NS, VAR_VEL, SET_NS, OUT_NM);
        rules[45] = rule_of(VAR_POS, SET_ZE, VAR_VEL, SET_NL, OUT_ZE);
        rules[46] = rule_of(VAR_POS, SET_PS, VAR_VEL, SET_NL, OUT_PM);
        rules[47] = rule_of(VAR_POS, SET_NL, VAR_VEL, SET_NS, OUT_NM);
        rules[48] = rule_of(VAR_POS, SET_NS, VAR_VEL, SET_NL, OUT_NM);
        rules[49] = rule_of(VAR_POS, SET_NL, VAR_VEL, SET_NL, OUT_NM);
    endtask

    // ---------------- driving ----------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input fpc_in_t d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (in_stall);
        force_q.push_back(predict_force(d));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (force_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves cfg_write high; the caller drops it after the last write
    task automatic write_level(input logic [1:0] idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        level[idx] = val;
    endtask

    task automatic set_levels(input logic [7:0] vl, input logic [7:0] lg,
                              input logic [7:0] md, input logic [7:0] sm);
        drain();
        write_level(CFG_VERY_LARGE, vl);
        write_level(CFG_LARGE, lg);
        write_level(CFG_MEDIUM, md);
        write_level(CFG_SMALL, sm);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] pick_field(input int v, input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'($urandom);
        if (r < 35)
            return 16'(to_q(mf_milli[v][$urandom_range(0, 4)][$urandom_range(0, 3)])
                       + $urandom_range(0, 6) - 3);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic fpc_in_t random_sample();
        fpc_in_t d;
        d.cart_position = pick_field(VAR_POS, 1100);
        d.cart_velocity = pick_field(VAR_VEL, 7500);
        d.pole_angle    = pick_field(VAR_ANG, 2500);
        d.pole_rate     = pick_field(VAR_RATE, 1100);
        return d;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        fpc_in_t d;
        send_item('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_item('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_item('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
        send_item('{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000});
        send_item('{-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF});
        send_item('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});
        // every trapezoid breakpoint and the first shoulder breakpoint, all variables together
        for (int s = 0; s < 5; s++)
            for (int p = 0; p < 4; p += 1 + (mf_shape[0][s] != SHP_TRAP ? 2 : 0))
            begin
                d.cart_position = 16'(to_q(mf_milli[VAR_POS][s][p]));
                d.cart_velocity = 16'(to_q(mf_milli[VAR_VEL][s][p]));
                d.pole_angle    = 16'(to_q(mf_milli[VAR_ANG][s][p]));
                d.pole_rate     = 16'(to_q(mf_milli[VAR_RATE][s][p]));
                send_item(d);
            end
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                no_gap = ($urandom_range(0, 3) == 0);
            send_item(random_sample());
        end
        no_gap = 1'b0;
    endtask

    task automatic test_output_hold();
        drain();
        hold_req = HOLD_LEN;
        no_gap = 1'b1;
        for (int i = 0; i < 8; i++)
            send_item(random_sample());
        no_gap = 1'b0;
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 5; i++)
            send_item(random_sample());
        drain();
        for (int i = 0; i < 5; i++)
            send_item(random_sample());
    endtask

    // ---------------- result side ----------------
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        fpc_out_t exp_r;
        stall_left = 0;
        free_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (force_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result force=%0d flag=%0b",
                                 $signed(out_data.drive_force), out_data.no_rule_fired);
                end
                else
                begin
                    exp_r = force_q.pop_front();
                    if (out_data.drive_force !== exp_r.drive_force
                        || out_data.no_rule_fired !== exp_r.no_rule_fired)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("force mismatch exp=%0d/%0b got=%0d/%0b",
                                     $signed(exp_r.drive_force), exp_r.no_rule_fired,
                                     $signed(out_data.drive_force), out_data.no_rule_fired);
                    end
                end
            end
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                free_left = 0;
                hold_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    free_left = $urandom_range(1, (r < 10) ? 300 : 20);
                    out_stall <= 1'b0;
                end
                else
                begin
                    stall_left = (r < 97) ? $urandom_range(0, 4) : $urandom_range(20, 80);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("fuzzy_pendulum_controller verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        wdog       = 0;
        hold_req   = 0;
        no_gap     = 1'b0;
        level[CFG_VERY_LARGE] = 8'd120;
        level[CFG_LARGE]      = 8'd40;
        level[CFG_MEDIUM]     = 8'd13;
        level[CFG_SMALL]      = 8'd5;
        build_tables();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(120);
        test_output_hold();
        set_levels(8'd255, 8'd255, 8'd255, 8'd255);
        test_directed();
        test_random(80);
        set_levels(8'd0, 8'd0, 8'd0, 8'd0);
        test_random(40);
        set_levels(8'd255, 8'd0, 8'd255, 8'd0);
        test_random(80);
        test_sender_pause();
        set_levels(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        test_random(100);
        set_levels(8'd1, 8'd254, 8'd0, 8'd255);
        test_random(60);
        test_output_hold();
        drain();

        if (mismatches == 0)
            $display("fuzzy_pendulum_controller verification clean");
        else
            $display("fuzzy_pendulum_controller verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fpc_pkg.sv
rtl/fpc_ram.sv
rtl/fpc_divider.sv
rtl/fuzzy_pendulum_controller.sv
tb/fuzzy_pendulum_controller_tb.sv
